// ===== sv/arwt_pkg.sv =====
// Shared types and constants for the address region watch table.
// No dependencies; every other file of the block but arwt_ram and arwt_queue uses this package.
`default_nettype none

package arwt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;
  localparam int unsigned DEF_ADDR_WIDTH  = 32;
  localparam int unsigned NUM_TABLES      = 3;
  localparam int unsigned CFG_IDX_W       = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_QUERY       = 2'd0,
    CMD_INS_ALLOC   = 2'd1,
    CMD_INS_SUSPECT = 2'd2,
    CMD_INS_GUARD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TBL_ALLOC   = 2'd0,
    TBL_SUSPECT = 2'd1,
    TBL_GUARD   = 2'd2
  } tbl_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // classified command, front to back
  typedef struct packed {
    logic is_query;
    tbl_e tbl;
    logic in_module;
  } arwt_op_t;

endpackage

`default_nettype wire

// ===== sv/arwt_if.sv =====
// Handshake channels of the address region watch table: input, result, config.
// Depends on arwt_pkg for default widths.
`default_nettype none

interface arwt_in_if #(
  parameter int unsigned AW = arwt_pkg::DEF_ADDR_WIDTH
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    command;
  logic [AW-1:0] address;
  logic [AW-1:0] region_size;

  modport source (output valid, command, address, region_size, input ready);
  modport sink   (input valid, command, address, region_size, output ready);
endinterface

interface arwt_out_if ();
  logic       valid;
  logic       ready;
  logic       in_red_zone;
  logic       in_guard_page;
  logic [1:0] status;

  modport source (output valid, in_red_zone, in_guard_page, status, input ready);
  modport sink   (input valid, in_red_zone, in_guard_page, status, output ready);
endinterface

interface arwt_cfg_if #(
  parameter int unsigned AW = arwt_pkg::DEF_ADDR_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [arwt_pkg::CFG_IDX_W-1:0] index;
  logic [AW-1:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/arwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arwt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [IW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/arwt_front.sv =====
// Front end: takes input words, holds the module bounds registers and
// classifies each command. Depends on arwt_pkg and arwt_if.
`default_nettype none

module arwt_front #(
  parameter int unsigned AW = arwt_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  arwt_in_if.sink                 in_i,
  arwt_cfg_if.sink                cfg_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output arwt_pkg::arwt_op_t      op_o,
  output logic [AW-1:0]           addr_o,
  output logic [AW-1:0]           size_o
);
  import arwt_pkg::*;

  logic [AW-1:0] base_q, limit_q;
  cmd_e          cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_MODULE_BASE) begin
        base_q <= cfg_i.data;
      end else if (cfg_i.index == REG_MODULE_LIMIT) begin
        limit_q <= cfg_i.data;
      end
    end
  end

  assign cmd = cmd_e'(in_i.command);

  always_comb begin
    op_o.is_query  = 1'b0;
    op_o.tbl       = TBL_ALLOC;
    // bounds are exclusive on both sides
    op_o.in_module = (base_q < in_i.address) && (limit_q > in_i.address);
    unique case (cmd)
      CMD_QUERY: begin
        op_o.is_query = 1'b1;
      end
      CMD_INS_ALLOC:   op_o.tbl = TBL_ALLOC;
      CMD_INS_SUSPECT: op_o.tbl = TBL_SUSPECT;
      CMD_INS_GUARD:   op_o.tbl = TBL_GUARD;
      default:         op_o.tbl = TBL_ALLOC;
    endcase
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign addr_o       = in_i.address;
  assign size_o       = in_i.region_size;

endmodule

`default_nettype wire

// ===== sv/arwt_queue.sv =====
// Two-entry queue between front and back so each side stalls on its own.
// No package dependencies.
`default_nettype none

module arwt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/arwt_back.sv =====
// Back end: scans the three region tables one entry per read, applies
// inserts and holds the result register. Depends on arwt_pkg, arwt_ram, arwt_if.
`default_nettype none

module arwt_back #(
  parameter int unsigned DEPTH = arwt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = arwt_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  input  wire arwt_pkg::arwt_op_t  op_i,
  input  wire logic [AW-1:0]       addr_i,
  input  wire logic [AW-1:0]       size_i,
  arwt_out_if.source               out_o
);
  import arwt_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_e;

  state_e                          state_q;
  arwt_op_t                        op_q;
  logic [AW-1:0]                   addr_q, size_q;
  logic [CW-1:0]                   idx_q, lim_q;
  logic [NUM_TABLES-1:0][CW-1:0]   cnt_q;
  logic [NUM_TABLES-1:0]           hit_q;
  logic                            dup_q;
  logic                            out_valid_q, red_q, guard_q;
  status_e                         status_q;

  logic [NUM_TABLES-1:0][2*AW-1:0] rdata;
  logic [NUM_TABLES-1:0][AW-1:0]   ent_start, ent_size, ent_off;
  logic [NUM_TABLES-1:0]           ent_valid, hit_now, eq_now;
  logic                            pop, out_free, do_write, dup_sel, full_sel;
  logic [CW-1:0]                   cnt_pop, cnt_fin, cnt_max01, cnt_max, idx_nxt;
  logic [NUM_TABLES-1:0]           we;

  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_o.ready;
  assign idx_nxt     = idx_q + CW'(1);

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
    arwt_ram #(
      .WIDTH (2 * AW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[t]),
      .waddr_i (cnt_fin[IW-1:0]),
      .wdata_i ({addr_q, size_q}),
      .raddr_i (idx_q[IW-1:0]),
      .rdata_o (rdata[t])
    );

    // entries fill in order and never leave, so the fill count marks valid ones
    assign ent_start[t] = rdata[t][2*AW-1:AW];
    assign ent_size[t]  = rdata[t][AW-1:0];
    assign ent_off[t]   = addr_q - ent_start[t];
    assign ent_valid[t] = idx_q < cnt_q[t];
    assign hit_now[t]   = ent_valid[t] && (addr_q >= ent_start[t]) &&
                          (ent_off[t] <= ent_size[t]);
    assign eq_now[t]    = ent_valid[t] && (addr_q == ent_start[t]);
    assign we[t]        = do_write && (op_q.tbl == tbl_e'(2'(t)));
  end

  // scan length: longest table for a query, the chosen table for an insert
  assign cnt_max01 = (cnt_q[0] > cnt_q[1]) ? cnt_q[0] : cnt_q[1];
  assign cnt_max   = (cnt_max01 > cnt_q[2]) ? cnt_max01 : cnt_q[2];

  always_comb begin
    unique case (op_i.tbl)
      TBL_ALLOC:   cnt_pop = cnt_q[0];
      TBL_SUSPECT: cnt_pop = cnt_q[1];
      TBL_GUARD:   cnt_pop = cnt_q[2];
      default:     cnt_pop = '0;
    endcase
  end

  always_comb begin
    unique case (op_q.tbl)
      TBL_ALLOC: begin
        cnt_fin = cnt_q[0];
        dup_sel = eq_now[0];
      end
      TBL_SUSPECT: begin
        cnt_fin = cnt_q[1];
        dup_sel = eq_now[1];
      end
      TBL_GUARD: begin
        cnt_fin = cnt_q[2];
        dup_sel = eq_now[2];
      end
      default: begin
        cnt_fin = '0;
        dup_sel = 1'b0;
      end
    endcase
  end

  assign full_sel = (cnt_fin == CNT_FULL);
  assign do_write = (state_q == S_FINISH) && out_free && !op_q.is_query &&
                    !dup_q && !full_sel;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q   <= op_i;
      addr_q <= addr_i;
      size_q <= size_i;
      lim_q  <= op_i.is_query ? cnt_max : cnt_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      hit_q       <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
      red_q       <= 1'b0;
      guard_q     <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            idx_q   <= '0;
            hit_q   <= '0;
            dup_q   <= 1'b0;
            state_q <= ((op_i.is_query ? cnt_max : cnt_pop) == '0) ? S_FINISH : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          hit_q   <= hit_q | hit_now;
          dup_q   <= dup_q | dup_sel;
          idx_q   <= idx_nxt;
          state_q <= (idx_nxt == lim_q) ? S_FINISH : S_READ;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (op_q.is_query) begin
              red_q    <= op_q.in_module || hit_q[0] || hit_q[1];
              guard_q  <= hit_q[2];
              status_q <= ST_DONE;
            end else begin
              red_q   <= 1'b0;
              guard_q <= 1'b0;
              if (dup_q) begin
                status_q <= ST_DUP;
              end else if (full_sel) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_DONE;
              end
            end
            for (int t = 0; t < NUM_TABLES; t++) begin
              if (we[t]) begin
                cnt_q[t] <= cnt_q[t] + CW'(1);
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.in_red_zone   = red_q;
  assign out_o.in_guard_page = guard_q;
  assign out_o.status        = status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_FULL) && (cnt_q[1] <= CNT_FULL) && (cnt_q[2] <= CNT_FULL))
    else $error("table fill count past depth");

  a_cnt_only_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FINISH) |=> $stable(cnt_q))
    else $error("fill count moved outside finish");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result raised without a finished scan");

  a_insert_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_DONE)) |-> (!red_q && !guard_q))
    else $error("insert word reports hit flags");

endmodule

`default_nettype wire

// ===== sv/address_region_watch_table.sv =====
// Top level of the address region watch table: front, queue and back.
// Depends on arwt_pkg, arwt_if, arwt_front, arwt_queue, arwt_back, arwt_ram.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    command, address, region_size
//   out_o    out  valid/ready    in_red_zone, in_guard_page, status
//   cfg_i    in   valid/ready    index, data (0 module_base, 1 module_limit)
//
// The back scans L entries per word, L being the fill count of the
// chosen table for an insert or the largest of the three for a query; the
// table RAM's registered read port gives each entry a read and a check state.
// Reset clears the fill counts and bounds; table contents need no clearing.
// A two-word queue sits behind the input, and the result register lets the
// back start the next scan while a result waits on out_o.
`default_nettype none

module address_region_watch_table #(
  parameter int unsigned TABLE_DEPTH = arwt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned ADDR_WIDTH  = arwt_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  arwt_in_if.sink     in_i,
  arwt_out_if.source  out_o,
  arwt_cfg_if.sink    cfg_i
);
  import arwt_pkg::*;

  localparam int unsigned QW = $bits(arwt_op_t) + 2 * ADDR_WIDTH;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  arwt_op_t              push_op, pop_op;
  logic [ADDR_WIDTH-1:0] push_addr, push_size, pop_addr, pop_size;
  logic [QW-1:0]         pop_data;

  arwt_front #(
    .AW (ADDR_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .op_o         (push_op),
    .addr_o       (push_addr),
    .size_o       (push_size)
  );

  arwt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_op, push_addr, push_size}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {pop_op, pop_addr, pop_size} = pop_data;

  arwt_back #(
    .DEPTH (TABLE_DEPTH),
    .AW    (ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .op_i        (pop_op),
    .addr_i      (pop_addr),
    .size_i      (pop_size),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/address_region_watch_table_tb.sv =====
// Self-checking bench for address_region_watch_table: directed table, then random phases.
// Keeps its own region tables and bounds to predict each result word the plan does not pin.
// Depends on arwt_pkg, the arwt_if channel interfaces and address_region_watch_table.
`timescale 1ns / 1ps

module address_region_watch_table_tb;
  import arwt_pkg::*;

  localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
  localparam int unsigned AW          = DEF_ADDR_WIDTH;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_WORDS = 200;
  localparam int          PLAN_ROWS   = 21;
  // no register lives here; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  typedef struct packed {
    logic    red;
    logic    guard;
    status_e status;
  } verdict_t;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] start;
    logic [AW-1:0] span;
  } region_t;

  typedef struct packed {
    cmd_e          cmd;
    logic [AW-1:0] addr;
    logic [AW-1:0] span;
    int unsigned   reps;
    logic [AW-1:0] step;
    logic          pinned;
    verdict_t      want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  arwt_in_if  #(.AW(AW)) in_if ();
  arwt_out_if            out_if ();
  arwt_cfg_if #(.AW(AW)) cfg_if ();

  address_region_watch_table #(
    .TABLE_DEPTH(DEPTH),
    .ADDR_WIDTH (AW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  region_t       watch_regions [NUM_TABLES][DEPTH];
  logic [AW-1:0] mod_base;
  logic [AW-1:0] mod_limit;
  verdict_t      verdicts_due [$];
  int            mismatches;
  int            quiet_cycles;
  bit            calm;
  // travels with the input word: use the typed-in verdict instead of the prediction
  logic          pinned_now;
  verdict_t      pinned_want;
  plan_row_t     plan [PLAN_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic tbl_e table_of(cmd_e c);
    case (c)
      CMD_INS_SUSPECT: return TBL_SUSPECT;
      CMD_INS_GUARD:   return TBL_GUARD;
      default:         return TBL_ALLOC;
    endcase
  endfunction

  // inclusive span, no wrap: a - start never underflows once a >= start
  function automatic bit region_hit(tbl_e t, logic [AW-1:0] a);
    bit hit;
    hit = 1'b0;
    for (int e = 0; e < DEPTH; e++)
      if (watch_regions[t][e].valid && a >= watch_regions[t][e].start &&
          (a - watch_regions[t][e].start) <= watch_regions[t][e].span)
        hit = 1'b1;
    return hit;
  endfunction

  // duplicate start wins over a full table
  function automatic status_e region_insert(tbl_e t, logic [AW-1:0] s, logic [AW-1:0] n);
    int free_slot;
    free_slot = -1;
    for (int e = 0; e < DEPTH; e++) begin
      if (watch_regions[t][e].valid) begin
        if (watch_regions[t][e].start == s) return ST_DUP;
      end else if (free_slot < 0) begin
        free_slot = e;
      end
    end
    if (free_slot < 0) return ST_FULL;
    watch_regions[t][free_slot] = '{1'b1, s, n};
    return ST_DONE;
  endfunction

  function automatic verdict_t judge_word(cmd_e cmd, logic [AW-1:0] a, logic [AW-1:0] n);
    verdict_t v;
    v = '{1'b0, 1'b0, ST_DONE};
    if (cmd == CMD_QUERY) begin
      v.red   = (mod_base < a && mod_limit > a) ||
                region_hit(TBL_ALLOC, a) || region_hit(TBL_SUSPECT, a);
      v.guard = region_hit(TBL_GUARD, a);
    end else begin
      v.status = region_insert(table_of(cmd), a, n);
    end
    return v;
  endfunction

  task automatic push_word(input cmd_e cmd, input logic [AW-1:0] addr, input logic [AW-1:0] span,
                           input logic pin, input verdict_t want);
    while (!calm && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.address     <= addr;
    in_if.region_size <= span;
    pinned_now        <= pin;
    pinned_want       <= want;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // wait for every outstanding word; the first edge lets the monitor log the last accept
  task automatic drain_words();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdicts_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_bounds(input logic [AW-1:0] base, input logic [AW-1:0] limit);
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      case (i)
        0: begin
          cfg_if.index <= REG_MODULE_BASE;
          cfg_if.data  <= base;
        end
        1: begin
          cfg_if.index <= REG_UNMAPPED;
          cfg_if.data  <= $urandom;
        end
        default: begin
          cfg_if.index <= REG_MODULE_LIMIT;
          cfg_if.data  <= limit;
        end
      endcase
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 8);
  end

  // accepts, prediction, checking and the watchdog share one edge-sampled process
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    bit       moved;
    moved = 1'b0;
    if (cfg_if.valid && cfg_if.ready) begin
      moved = 1'b1;
      case (cfg_if.index)
        REG_MODULE_BASE:  mod_base  = cfg_if.data;
        REG_MODULE_LIMIT: mod_limit = cfg_if.data;
        default: ;
      endcase
    end
    if (in_if.valid && in_if.ready) begin
      moved = 1'b1;
      got = judge_word(cmd_e'(in_if.command), in_if.address, in_if.region_size);
      verdicts_due.insert(verdicts_due.size(), pinned_now ? pinned_want : got);
    end
    if (out_if.valid && out_if.ready) begin
      moved = 1'b1;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word red=%0b guard=%0b status=%0d", $time,
                   out_if.in_red_zone, out_if.in_guard_page, out_if.status);
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.in_red_zone !== want.red || out_if.in_guard_page !== want.guard ||
            out_if.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: word mismatch exp red=%0b guard=%0b status=%0d, got %0b %0b %0d",
                     $time, want.red, want.guard, want.status,
                     out_if.in_red_zone, out_if.in_guard_page, out_if.status);
        end
      end
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cmd_e          cmd;
    tbl_e          tsel;
    region_t       pick;
    logic [AW-1:0] addr;
    logic [AW-1:0] span;
    logic [AW-1:0] b;
    logic [AW-1:0] l;
    logic [AW:0]   reach;

    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_QUERY;
    in_if.address     <= '0;
    in_if.region_size <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_MODULE_BASE;
    cfg_if.data       <= '0;
    pinned_now        <= 1'b0;
    pinned_want       <= '{1'b0, 1'b0, ST_DONE};
    foreach (watch_regions[t, e]) watch_regions[t][e] = '0;
    mod_base     = '0;
    mod_limit    = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;

    //        cmd              addr          span          reps step         pin  verdict
    plan = '{
      '{CMD_QUERY,       32'h0000_0000, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      // module bounds are exclusive
      '{CMD_QUERY,       32'h4000_0000, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'h4000_0001, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b1, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'h4000_1000, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_INS_ALLOC,   32'h0000_1000, 32'h0000_0100, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_INS_ALLOC,   32'h0000_1000, 32'h0000_0007, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DUP}},
      '{CMD_QUERY,       32'h0000_1100, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b1, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'h0000_1101, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      // guard region running past the top of memory
      '{CMD_INS_GUARD,   32'hFFFF_FF00, 32'hFFFF_FFFF, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b1, ST_DONE}},
      '{CMD_INS_SUSPECT, 32'h0000_0000, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'h0000_0000, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b1, 1'b0, ST_DONE}},
      '{CMD_INS_SUSPECT, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0,       1'b1, '{1'b1, 1'b1, ST_DONE}},
      // fill the allocated table, then overflow it
      '{CMD_INS_ALLOC,   32'h0001_0000, 32'h0000_00FF, 15, 32'h1_0000, 1'b1, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_INS_ALLOC,   32'h8000_0000, 32'h0000_0005, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_FULL}},
      '{CMD_INS_ALLOC,   32'h0000_1000, 32'h0000_0100, 1, 32'h0,       1'b1, '{1'b0, 1'b0, ST_DUP}},
      '{CMD_QUERY,       32'h000A_0080, 32'h1234_5678, 1, 32'h0,       1'b0, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_INS_GUARD,   32'h7FFF_FFFF, 32'h0000_0001, 1, 32'h0,       1'b0, '{1'b0, 1'b0, ST_DONE}},
      '{CMD_QUERY,       32'h8000_0000, 32'h0000_0000, 1, 32'h0,       1'b0, '{1'b0, 1'b0, ST_DONE}}
    };

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_bounds(32'h4000_0000, 32'h4000_1000);
    foreach (plan[i])
      for (int r = 0; r < plan[i].reps; r++)
        push_word(plan[i].cmd, plan[i].addr + AW'(r) * plan[i].step, plan[i].span,
                  plan[i].pinned, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin b = '0;       l = '0;       end
        1: begin b = '0;       l = '1;       end
        2: begin b = '1;       l = '0;       end
        3: begin b = $urandom; l = b;        end
        4: begin b = $urandom; l = b + AW'($urandom_range(65535, 1)); end
        default: begin b = $urandom; l = $urandom; end
      endcase
      drain_words();
      load_bounds(b, l);
      calm = (ph == 1);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        cmd  = ($urandom_range(99) < 55) ? CMD_QUERY : cmd_e'($urandom_range(3, 1));
        tsel = (cmd == CMD_QUERY) ? tbl_e'($urandom_range(NUM_TABLES - 1)) : table_of(cmd);
        pick = watch_regions[tsel][$urandom_range(DEPTH - 1)];
        reach = {1'b0, pick.start} + {1'b0, pick.span};
        if (reach[AW]) reach = {1'b0, {AW{1'b1}}};
        if (cmd == CMD_QUERY) begin
          span = $urandom;
          case ($urandom_range(9))
            0, 1: addr = $urandom;
            2:    addr = mod_base + AW'($urandom_range(2)) - AW'(1);
            3:    addr = mod_limit + AW'($urandom_range(2)) - AW'(1);
            4:    addr = $urandom_range(1) ? '1 : '0;
            default: begin
              if (!pick.valid) addr = $urandom;
              else begin
                case ($urandom_range(3))
                  0: addr = pick.start - AW'(1);
                  1: addr = pick.start;
                  2: addr = reach[AW-1:0];
                  default: addr = reach[AW-1:0] + AW'(1);
                endcase
              end
            end
          endcase
        end else begin
          if (pick.valid && $urandom_range(3) == 0) addr = pick.start;
          else begin
            case ($urandom_range(3))
              0: addr = $urandom;
              1: addr = $urandom & 32'h000F_FF00;
              2: addr = ~AW'($urandom_range(4095));
              default: addr = AW'($urandom_range(255));
            endcase
          end
          case ($urandom_range(4))
            0: span = '0;
            1: span = '1;
            2: span = $urandom;
            default: span = AW'($urandom_range(16'hFFFF));
          endcase
        end
        push_word(cmd, addr, span, 1'b0, '{1'b0, 1'b0, ST_DONE});
      end
    end

    drain_words();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/arwt_pkg.sv
sv/arwt_if.sv
sv/arwt_ram.sv
sv/arwt_front.sv
sv/arwt_queue.sv
sv/arwt_back.sv
sv/address_region_watch_table.sv
tb/address_region_watch_table_tb.sv
